FILE: rtl/core/ecv_pkg.sv
// Shared definitions for the easing curve evaluator.
// Holds the curve selector codes; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ecv_pkg;

  // Width of the curve selector carried in tuser
  localparam int unsigned SelW = 3;

  // Curve selector codes; any other code passes progress through
  typedef enum logic [SelW-1:0] {
    CurveLinear  = 3'd0,
    CurveIn      = 3'd1,
    CurveOut     = 3'd2,
    CurveInOut   = 3'd3,
    CurveBounce  = 3'd4,
    CurveElastic = 3'd5
  } curve_e;

endpackage

`default_nettype wire

FILE: rtl/core/ecv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ecv_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/ecv_rom.sv
// Elastic-out sample table: constant entries built at elaboration, copied into
// a RAM by a load sweep after reset. Depends on ecv_ram.
`timescale 1ns / 1ps
`default_nettype none

module ecv_rom #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned Width = FRAC_BITS + 2,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [AddrW-1:0]        rd_addr_i,
  output logic signed [Width-1:0] rd_data_o,
  output logic                    ready_o
);

  localparam longint unsigned Q30 = 64'd1 << 30;
  localparam longint unsigned Ln2Q30 = 64'd744261118;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned D = 64'(DEPTH);
  localparam longint unsigned Fb = 64'(FRAC_BITS);

  logic [Width-1:0] tbl [DEPTH];

  // Build each entry: 2^(-10x) * sin((10x - 0.75) * 2pi/3) at x = i/DEPTH
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
    localparam longint unsigned Idx = 64'(gi);
    // phase in quarter turns, folded into the first quadrant
    localparam longint unsigned P = (40 * Idx + 9 * D) % (12 * D);
    localparam longint unsigned P32 = (P << 32) / (12 * D);
    localparam longint unsigned Quad = (P32 >> 30) & 64'd3;
    localparam longint unsigned F0 = P32 & (Q30 - 1);
    localparam longint unsigned Fa = ((Quad & 64'd1) != 0) ? (Q30 - F0) : F0;
    localparam longint unsigned Ang = (Fa * HalfPiQ30) >> 30;
    localparam longint unsigned Ang2 = (Ang * Ang) >> 30;
    // sine series to the x^21 term
    localparam longint unsigned S1 = ((Ang * Ang2) >> 30) / 6;
    localparam longint unsigned S2 = ((S1 * Ang2) >> 30) / 20;
    localparam longint unsigned S3 = ((S2 * Ang2) >> 30) / 42;
    localparam longint unsigned S4 = ((S3 * Ang2) >> 30) / 72;
    localparam longint unsigned S5 = ((S4 * Ang2) >> 30) / 110;
    localparam longint unsigned S6 = ((S5 * Ang2) >> 30) / 156;
    localparam longint unsigned S7 = ((S6 * Ang2) >> 30) / 210;
    localparam longint unsigned S8 = ((S7 * Ang2) >> 30) / 272;
    localparam longint unsigned S9 = ((S8 * Ang2) >> 30) / 342;
    localparam longint unsigned S10 = ((S9 * Ang2) >> 30) / 420;
    localparam longint unsigned Sin = Ang - S1 + S2 - S3 + S4 - S5 + S6 - S7 + S8 - S9 + S10;
    // decay: whole octaves as a shift, the rest through an exp series
    localparam longint unsigned E10 = 10 * Idx;
    localparam longint unsigned Oct = E10 / D;
    localparam longint unsigned Rem = E10 % D;
    localparam longint unsigned Y = (Ln2Q30 * Rem) / D;
    localparam longint unsigned X1 = ((Q30 * Y) >> 30) / 1;
    localparam longint unsigned X2 = ((X1 * Y) >> 30) / 2;
    localparam longint unsigned X3 = ((X2 * Y) >> 30) / 3;
    localparam longint unsigned X4 = ((X3 * Y) >> 30) / 4;
    localparam longint unsigned X5 = ((X4 * Y) >> 30) / 5;
    localparam longint unsigned X6 = ((X5 * Y) >> 30) / 6;
    localparam longint unsigned X7 = ((X6 * Y) >> 30) / 7;
    localparam longint unsigned X8 = ((X7 * Y) >> 30) / 8;
    localparam longint unsigned X9 = ((X8 * Y) >> 30) / 9;
    localparam longint unsigned X10 = ((X9 * Y) >> 30) / 10;
    localparam longint unsigned X11 = ((X10 * Y) >> 30) / 11;
    localparam longint unsigned X12 = ((X11 * Y) >> 30) / 12;
    localparam longint unsigned X13 = ((X12 * Y) >> 30) / 13;
    localparam longint unsigned X14 = ((X13 * Y) >> 30) / 14;
    localparam longint unsigned ExpSum = Q30 + X1 + X2 + X3 + X4 + X5 + X6 + X7
                                        + X8 + X9 + X10 + X11 + X12 + X13 + X14;
    localparam longint unsigned Decay = (64'd1 << 60) / ExpSum;
    localparam longint unsigned Mag = Sin * Decay;
    localparam longint unsigned Sh = 60 + Oct - Fb;
    localparam longint unsigned V = (Mag + (64'd1 << (Sh - 1))) >> Sh;
    localparam longint unsigned Entry = (Quad >= 2) ? (64'd0 - V) : V;

    assign tbl[gi] = Width'(Entry);
  end

  logic [AddrW-1:0] fill_idx_q, fill_idx_d;
  logic             ready_q, ready_d;
  logic [Width-1:0] rdata;

  // Advance the load sweep one entry a cycle until the last one is written
  always_comb begin
    fill_idx_d = fill_idx_q;
    ready_d    = ready_q;
    if (!ready_q) begin
      if (fill_idx_q == AddrW'(DEPTH - 1)) begin
        ready_d = 1'b1;
      end else begin
        fill_idx_d = fill_idx_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_idx_q <= '0;
      ready_q    <= 1'b0;
    end else begin
      fill_idx_q <= fill_idx_d;
      ready_q    <= ready_d;
    end
  end

  ecv_ram #(
    .WIDTH(Width),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (!ready_q),
    .waddr_i(fill_idx_q),
    .wdata_i(tbl[fill_idx_q]),
    .re_i   (rd_en_i),
    .raddr_i(rd_addr_i),
    .rdata_o(rdata)
  );

  assign rd_data_o = $signed(rdata);
  assign ready_o   = ready_q;

endmodule

`default_nettype wire

FILE: rtl/core/easing_curve_evaluator_top.sv
// Channel     Dir  tdata                        tuser
// s_axis      in   progress (Q1.FRAC_BITS)      curve_select
// m_axis      out  eased_value (signed Q2.x)    -
//
// One word per cycle sustained while m_axis_tready is high; each word passes four
// register stages in order (clamp, operand, square and table read, finish), the
// last of them being the output register. After reset the elastic table loads,
// with s_axis_tready low. A stall on m_axis holds each stage that is full and lets
// empty stages fill; no word is dropped or repeated.
// Top level of the easing curve evaluator; depends on ecv_pkg and ecv_rom.
`timescale 1ns / 1ps
`default_nettype none

module easing_curve_evaluator_top #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned ELASTIC_ROM_DEPTH = 1024,
  localparam int unsigned InDataW = ((FRAC_BITS + 1 + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((FRAC_BITS + 2 + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [InDataW-1:0]         s_axis_tdata,  // [FRAC_BITS:0] progress
  input  logic [ecv_pkg::SelW-1:0]   s_axis_tuser,  // [2:0] curve_select
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [OutDataW-1:0]        m_axis_tdata   // [FRAC_BITS+1:0] eased_value
);

  import ecv_pkg::*;

  localparam int unsigned PW    = FRAC_BITS + 1;
  localparam int unsigned RsW   = FRAC_BITS + 2;
  localparam int unsigned OpW   = FRAC_BITS + 3;
  localparam int unsigned ExtW  = FRAC_BITS + 6;
  localparam int unsigned SqW   = 2 * OpW;
  localparam int unsigned AccW  = SqW + 2;
  localparam int unsigned AddrW = $clog2(ELASTIC_ROM_DEPTH);
  localparam int unsigned ProdW = PW + AddrW;

  localparam logic [PW-1:0]   One  = PW'(1) << FRAC_BITS;
  localparam logic [ExtW-1:0] OneX = ExtW'(1) << FRAC_BITS;
  localparam logic [AccW-1:0] HalfA = AccW'(1) << (FRAC_BITS - 1);
  localparam logic [AccW-1:0] OneA = AccW'(1) << FRAC_BITS;
  localparam logic [AccW-1:0] BounceRnd = AccW'(1) << (FRAC_BITS + 5);

  // Stage valids and advance enables
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en_o;
  logic rom_ready;

  assign en_o = !vo_q || m_axis_tready;
  assign en3  = !v3_q || en_o;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;

  assign s_axis_tready = en1 && rom_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid && rom_ready;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en_o) vo_q <= v3_q;
    end
  end

  // Stage 1: saturate progress to one
  curve_e        sel1_q;
  logic [PW-1:0] raw1_q, a1_q;
  logic [PW-1:0] raw_in;

  assign raw_in = s_axis_tdata[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sel1_q <= curve_e'(s_axis_tuser);
      raw1_q <= raw_in;
      a1_q   <= (raw_in > One) ? One : raw_in;
    end
  end

  // Stage 2: pick the operand to square, bounce segment, table address
  logic [ExtW-1:0]  a_ext, a11, a22, m_one, bdist;
  logic [5:0]       k64_d;
  logic             hi_d;
  logic [OpW-1:0]   op_d;
  logic [ProdW-1:0] addr_prod;
  logic [AddrW-1:0] addr_d;

  always_comb begin
    a_ext = ExtW'(a1_q);
    a11   = a_ext * ExtW'(11);
    a22   = a_ext * ExtW'(22);
    if (a11 < OneX * ExtW'(4)) begin
      m_one = '0;
      k64_d = 6'd0;
    end else if (a11 < OneX * ExtW'(8)) begin
      m_one = OneX * ExtW'(12);
      k64_d = 6'd48;
    end else if (a11 < OneX * ExtW'(10)) begin
      m_one = OneX * ExtW'(18);
      k64_d = 6'd60;
    end else begin
      m_one = OneX * ExtW'(21);
      k64_d = 6'd63;
    end
    bdist = (a22 >= m_one) ? (a22 - m_one) : (m_one - a22);
    hi_d  = ((a_ext << 1) >= OneX);

    unique case (sel1_q)
      CurveOut:    op_d = OpW'(OneX - a_ext);
      CurveInOut:  op_d = hi_d ? OpW'((OneX << 1) - (a_ext << 1)) : OpW'(a_ext);
      CurveBounce: op_d = OpW'(bdist);
      default:     op_d = OpW'(a_ext);
    endcase

    addr_prod = ProdW'(a1_q) * ProdW'(ELASTIC_ROM_DEPTH);
    addr_d    = (a1_q == One) ? '0 : addr_prod[FRAC_BITS +: AddrW];
  end

  curve_e           sel2_q;
  logic [PW-1:0]    raw2_q, a2_q;
  logic [OpW-1:0]   op2_q;
  logic [5:0]       k64_2_q;
  logic             hi2_q;
  logic [AddrW-1:0] addr2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sel2_q  <= sel1_q;
      raw2_q  <= raw1_q;
      a2_q    <= a1_q;
      op2_q   <= op_d;
      k64_2_q <= k64_d;
      hi2_q   <= hi_d;
      addr2_q <= addr_d;
    end
  end

  // Stage 3: square the operand; the table word is read alongside
  curve_e                rom_sel;
  logic signed [RsW-1:0] rom_rdata;
  curve_e                sel3_q;
  logic [PW-1:0]         raw3_q, a3_q;
  logic [SqW-1:0]        sq3_q;
  logic [5:0]            k64_3_q;
  logic                  hi3_q;

  assign rom_sel = sel2_q;

  ecv_rom #(
    .FRAC_BITS(FRAC_BITS),
    .DEPTH    (ELASTIC_ROM_DEPTH)
  ) u_rom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (en3 && v2_q && (rom_sel == CurveElastic)),
    .rd_addr_i(addr2_q),
    .rd_data_o(rom_rdata),
    .ready_o  (rom_ready)
  );

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sel3_q  <= sel2_q;
      raw3_q  <= raw2_q;
      a3_q    <= a2_q;
      sq3_q   <= SqW'(op2_q) * SqW'(op2_q);
      k64_3_q <= k64_2_q;
      hi3_q   <= hi2_q;
    end
  end

  // Stage 4: round, shift and offset per curve
  logic [AccW-1:0] sqx;
  logic [RsW-1:0]  res_d, res_q;

  always_comb begin
    sqx = AccW'(sq3_q);
    unique case (sel3_q)
      CurveLinear: res_d = RsW'(a3_q);
      CurveIn:     res_d = RsW'((sqx + HalfA) >> FRAC_BITS);
      CurveOut:    res_d = RsW'(One) - RsW'((sqx + HalfA) >> FRAC_BITS);
      CurveInOut: begin
        if (hi3_q) begin
          res_d = RsW'(One) - RsW'((sqx + OneA) >> (FRAC_BITS + 1));
        end else begin
          res_d = RsW'(((sqx << 1) + HalfA) >> FRAC_BITS);
        end
      end
      CurveBounce: res_d = RsW'((sqx + BounceRnd) >> (FRAC_BITS + 6))
                           + (RsW'(k64_3_q) << (FRAC_BITS - 6));
      CurveElastic: begin
        if (a3_q == '0) begin
          res_d = '0;
        end else if (a3_q == One) begin
          res_d = RsW'(One);
        end else begin
          res_d = RsW'(One) + RsW'(rom_rdata);
        end
      end
      default:     res_d = RsW'(raw3_q);
    endcase
  end

  // Output register; holds while the sink stalls
  always_ff @(posedge clk_i) begin
    if (en_o) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = OutDataW'(res_q);

  // Nothing enters the pipeline while the elastic table is still loading
  a_no_work_while_loading : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rom_ready |-> !(v1_q || v2_q || v3_q || vo_q))
    else $error("pipeline holds a word while the elastic table loads");

  // Quadratic curves stay within zero to one
  a_quad_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && (sel3_q == CurveIn || sel3_q == CurveOut || sel3_q == CurveInOut)
    |-> res_d <= RsW'(One))
    else $error("quadratic curve result above one");

  // Table word must hold while its stage is stalled
  a_rom_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !en3 |=> $stable(rom_rdata))
    else $error("table read data changed under a stalled stage");

endmodule

`default_nettype wire
